/* hdl/c8core_pkg.sv */
`default_nettype none
package c8core_pkg;

  localparam int MEM_BYTES       = 4096;
  localparam int MEM_AW          = $clog2(MEM_BYTES);
  localparam int STACK_DEPTH_DEF = 16;
  localparam int FONT_BYTES      = 80;
  localparam logic [MEM_AW-1:0] FONT_BASE = MEM_AW'(12'h050);
  localparam logic [11:0]       START_PC  = 12'h200;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef enum logic [1:0] {ACT_EXEC, ACT_WRITE, ACT_READ, ACT_NONE} action_e;
  typedef enum logic [1:0] {ST_OK, ST_UNKNOWN, ST_OVERFLOW, ST_UNDERFLOW} status_e;
  typedef enum logic [2:0] {OC_SIMPLE, OC_FLAG, OC_BCD, OC_STORE, OC_LOAD} op_class_e;
  typedef enum logic [1:0] {MR_PC, MR_PC1, MR_ADDR, MR_IK} mrsel_e;
  typedef enum logic [1:0] {MW_ADDR, MW_BCD, MW_STORE} mwsel_e;
  typedef enum logic [1:0] {VR_X, VR_Y, VR_ZERO, VR_CNT} vrsel_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_MEMW, S_MEMR0, S_MEMR1,
    S_F0, S_F1, S_F2, S_R0, S_R1, S_R2, S_EXEC, S_FLAG,
    S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR, S_DONE
  } state_e;

  typedef struct packed {
    logic   clr_we;
    logic   accept;
    mrsel_e mem_rsel;
    logic   mem_we;
    mwsel_e mem_wsel;
    logic   op_hi_ld;
    logic   op_lo_ld;
    logic   pc_step;
    vrsel_e v_rsel;
    logic   vx_ld;
    logic   vy_ld;
    logic   exec;
    logic   flag_wr;
    logic   v_load_wr;
    logic   rd_ld;
    logic   cnt_clr;
    logic   cnt_inc;
    logic   finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic        clr_done;
    action_e     action;
    logic [15:0] op;
    logic [3:0]  cnt;
    logic        out_free;
  } dp_stat_t;

  function automatic op_class_e op_class(logic [15:0] op);
    op_class_e c;
    c = OC_SIMPLE;
    if (op[15:12] == 4'h8) begin
      case (op[3:0])
        4'h4, 4'h5, 4'h6, 4'h7, 4'hE: c = OC_FLAG;
        default: c = OC_SIMPLE;
      endcase
    end else if (op[15:12] == 4'hF) begin
      case (op[7:0])
        8'h33:   c = OC_BCD;
        8'h55:   c = OC_STORE;
        8'h65:   c = OC_LOAD;
        default: c = OC_SIMPLE;
      endcase
    end
    return c;
  endfunction

  // sel 0 hundreds, 1 tens, 2 ones
  function automatic logic [7:0] bcd_digit(logic [7:0] v, logic [1:0] sel);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [14:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    logic [7:0]  d;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    p = 15'(r) * 15'd205;
    t = p[14:11];
    o = r - 8'(t) * 8'd10;
    case (sel)
      2'd0:    d = {6'b0, h};
      2'd1:    d = {4'b0, t};
      default: d = o;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

/* hdl/c8core_in_if.sv */
`default_nettype none
interface c8core_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [11:0] address;
  logic [7:0]  write_data;
  logic [15:0] keys;
  logic [7:0]  random_byte;

  modport source (output valid, action, address, write_data, keys, random_byte,
                  input ready);
  modport sink (input valid, action, address, write_data, keys, random_byte,
                output ready);
endinterface
`default_nettype wire

/* hdl/c8core_out_if.sv */
`default_nettype none
interface c8core_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pc;
  logic [15:0] opcode;
  logic [7:0]  read_data;
  logic        sound_on;
  logic        clear_display;
  logic        draw_request;
  logic        waiting_key;
  logic [1:0]  status;

  modport source (output valid, pc, opcode, read_data, sound_on, clear_display,
                  draw_request, waiting_key, status, input ready);
  modport sink (input valid, pc, opcode, read_data, sound_on, clear_display,
                draw_request, waiting_key, status, output ready);
endinterface
`default_nettype wire

/* hdl/c8core_ctrl.sv */
`default_nettype none
module c8core_ctrl
  import c8core_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dp_stat_t  stat_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat_i.action)
          ACT_EXEC:  state_d = S_F0;
          ACT_WRITE: state_d = S_MEMW;
          ACT_READ:  state_d = S_MEMR0;
          default:   state_d = S_DONE;
        endcase
      end
      S_MEMW: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.mem_wsel = MW_ADDR;
        state_d        = S_DONE;
      end
      S_MEMR0: begin
        cmd_o.mem_rsel = MR_ADDR;
        state_d        = S_MEMR1;
      end
      S_MEMR1: begin
        cmd_o.rd_ld = 1'b1;
        state_d     = S_DONE;
      end
      S_F0: begin
        cmd_o.mem_rsel = MR_PC;
        state_d        = S_F1;
      end
      S_F1: begin
        cmd_o.mem_rsel = MR_PC1;
        cmd_o.op_hi_ld = 1'b1;
        state_d        = S_F2;
      end
      S_F2: begin
        cmd_o.op_lo_ld = 1'b1;
        cmd_o.pc_step  = 1'b1;
        state_d        = S_R0;
      end
      S_R0: begin
        cmd_o.v_rsel = VR_X;
        state_d      = S_R1;
      end
      S_R1: begin
        cmd_o.v_rsel = (stat_i.op[15:12] == 4'hB) ? VR_ZERO : VR_Y;
        cmd_o.vx_ld  = 1'b1;
        state_d      = S_R2;
      end
      S_R2: begin
        cmd_o.vy_ld = 1'b1;
        state_d     = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        unique case (op_class(stat_i.op))
          OC_FLAG:  state_d = S_FLAG;
          OC_BCD:   state_d = S_BCD;
          OC_STORE: state_d = S_ST_RD;
          OC_LOAD:  state_d = S_LD_RD;
          default:  state_d = S_DONE;
        endcase
      end
      S_FLAG: begin
        cmd_o.flag_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_BCD: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.mem_wsel = MW_BCD;
        cmd_o.cnt_inc  = 1'b1;
        if (stat_i.cnt == 4'd2) state_d = S_DONE;
      end
      S_ST_RD: begin
        cmd_o.v_rsel = VR_CNT;
        state_d      = S_ST_WR;
      end
      S_ST_WR: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.mem_wsel = MW_STORE;
        cmd_o.cnt_inc  = 1'b1;
        state_d        = (stat_i.cnt == stat_i.op[11:8]) ? S_DONE : S_ST_RD;
      end
      S_LD_RD: begin
        cmd_o.mem_rsel = MR_IK;
        state_d        = S_LD_WR;
      end
      S_LD_WR: begin
        cmd_o.v_load_wr = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        state_d         = (stat_i.cnt == stat_i.op[11:8]) ? S_DONE : S_LD_RD;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/c8core_dpath.sv */
`default_nettype none
module c8core_dpath
  import c8core_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  output dp_stat_t       stat_o,
  c8core_in_if.sink      in_i,
  c8core_out_if.source   out_o
);

  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int SP_W  = $clog2(STACK_DEPTH + 1);

  // input word
  action_e     action_q;
  logic [11:0] addr_q;
  logic [7:0]  wdata_q;
  logic [15:0] keys_q;
  logic [7:0]  rnd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_e'(in_i.action);
      addr_q   <= in_i.address;
      wdata_q  <= in_i.write_data;
      keys_q   <= in_i.keys;
      rnd_q    <= in_i.random_byte;
    end
  end

  // architectural state
  logic [11:0]     pc_q, pc_d;
  logic [15:0]     i_q, i_d;
  logic [SP_W-1:0] sp_q, sp_d;
  logic [7:0]      dt_q, dt_d, st_q, st_d;
  logic [11:0]     stack_q [STACK_DEPTH];
  logic            stk_we;
  logic [IDX_W-1:0] stk_waddr;
  logic [11:0]     stk_wdata;
  logic [SP_W-1:0] sp_top;

  // work registers
  logic [15:0] op_q;
  logic [7:0]  vx_q, vy_q, rd_q;
  logic [3:0]  cnt_q;
  logic        cls_q, cls_d, drw_q, drw_d, wait_q, wait_d;
  status_e     status_q, status_d;

  // clearing pass
  logic [MEM_AW-1:0] clr_q;
  logic [MEM_AW-1:0] font_off;

  // main memory
  logic [7:0]        mem [MEM_BYTES];
  logic [7:0]        mem_rdata_q;
  logic [MEM_AW-1:0] mem_raddr, mem_waddr, ik_addr;
  logic [7:0]        mem_wdata;
  logic              mem_we;

  // V registers
  logic [7:0]  vmem [16];
  logic [15:0] vvalid_q;
  logic [7:0]  vraw_q;
  logic        vvld_q;
  logic [7:0]  v_rdata;
  logic [3:0]  v_raddr, v_waddr;
  logic [7:0]  v_wdata;
  logic        v_we;

  logic [3:0]  fx, fn;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [8:0]  sum9;
  logic        flag;
  logic        key_dn;
  logic [3:0]  kidx;
  logic        out_valid_q;

  assign fx  = op_q[11:8];
  assign fn  = op_q[3:0];
  assign kk  = op_q[7:0];
  assign nnn = op_q[11:0];

  assign ik_addr  = i_q[MEM_AW-1:0] + MEM_AW'(cnt_q);
  assign font_off = clr_q - FONT_BASE;

  always_comb begin
    case (cmd_i.mem_rsel)
      MR_PC:   mem_raddr = pc_q;
      MR_PC1:  mem_raddr = pc_q + 12'd1;
      MR_ADDR: mem_raddr = addr_q;
      default: mem_raddr = ik_addr;
    endcase
  end

  always_comb begin
    mem_we = cmd_i.clr_we | cmd_i.mem_we;
    if (cmd_i.clr_we) begin
      mem_waddr = clr_q;
      if (clr_q >= FONT_BASE && clr_q < FONT_BASE + MEM_AW'(FONT_BYTES)) begin
        mem_wdata = FONT[font_off[6:0]];
      end else begin
        mem_wdata = 8'h00;
      end
    end else begin
      case (cmd_i.mem_wsel)
        MW_ADDR: begin
          mem_waddr = addr_q;
          mem_wdata = wdata_q;
        end
        MW_BCD: begin
          mem_waddr = ik_addr;
          mem_wdata = bcd_digit(vx_q, cnt_q[1:0]);
        end
        default: begin
          mem_waddr = ik_addr;
          mem_wdata = v_rdata;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_we) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_comb begin
    case (cmd_i.v_rsel)
      VR_X:    v_raddr = fx;
      VR_Y:    v_raddr = op_q[7:4];
      VR_ZERO: v_raddr = 4'h0;
      default: v_raddr = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    vraw_q <= vmem[v_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vvalid_q <= '0;
      vvld_q   <= 1'b0;
    end else begin
      if (v_we) vvalid_q[v_waddr] <= 1'b1;
      vvld_q <= vvalid_q[v_raddr];
    end
  end

  assign v_rdata = vvld_q ? vraw_q : 8'h00;

  assign sum9   = {1'b0, vx_q} + {1'b0, vy_q};
  assign key_dn = (vx_q[7:4] == 4'h0) && keys_q[vx_q[3:0]];
  assign sp_top = sp_q - 1'b1;

  always_comb begin
    kidx = 4'h0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) kidx = 4'(k);
    end
  end

  always_comb begin
    case (fn)
      4'h4:    flag = sum9[8];
      4'h5:    flag = vx_q > vy_q;
      4'h6:    flag = vx_q[0];
      4'h7:    flag = vy_q > vx_q;
      default: flag = vx_q[7];
    endcase
  end

  always_comb begin
    pc_d      = pc_q;
    i_d       = i_q;
    sp_d      = sp_q;
    dt_d      = dt_q;
    st_d      = st_q;
    v_we      = 1'b0;
    v_waddr   = fx;
    v_wdata   = 8'h00;
    stk_we    = 1'b0;
    stk_waddr = sp_q[IDX_W-1:0];
    stk_wdata = pc_q;
    cls_d     = cls_q;
    drw_d     = drw_q;
    wait_d    = wait_q;
    status_d  = status_q;

    if (cmd_i.accept) begin
      cls_d    = 1'b0;
      drw_d    = 1'b0;
      wait_d   = 1'b0;
      status_d = ST_OK;
    end
    if (cmd_i.pc_step) pc_d = pc_q + 12'd2;

    if (cmd_i.exec) begin
      case (op_q[15:12])
        4'h0: begin
          if (op_q == 16'h00E0) begin
            cls_d = 1'b1;
          end else if (op_q == 16'h00EE) begin
            if (sp_q == '0) begin
              status_d = ST_UNDERFLOW;
            end else begin
              sp_d      = sp_top;
              pc_d      = stack_q[sp_top[IDX_W-1:0]];
              stk_we    = 1'b1;
              stk_waddr = sp_top[IDX_W-1:0];
              stk_wdata = 12'h000;
            end
          end else begin
            status_d = ST_UNKNOWN;
          end
        end
        4'h1: pc_d = nnn;
        4'h2: begin
          if (sp_q == SP_W'(STACK_DEPTH)) begin
            status_d = ST_OVERFLOW;
          end else begin
            stk_we = 1'b1;
            sp_d   = sp_q + 1'b1;
            pc_d   = nnn;
          end
        end
        4'h3: if (vx_q == kk) pc_d = pc_q + 12'd2;
        4'h4: if (vx_q != kk) pc_d = pc_q + 12'd2;
        4'h5: begin
          if (fn != 4'h0) status_d = ST_UNKNOWN;
          else if (vx_q == vy_q) pc_d = pc_q + 12'd2;
        end
        4'h6: begin
          v_we    = 1'b1;
          v_wdata = kk;
        end
        4'h7: begin
          v_we    = 1'b1;
          v_wdata = vx_q + kk;
        end
        4'h8: begin
          v_we = 1'b1;
          case (fn)
            4'h0: v_wdata = vy_q;
            4'h1: v_wdata = vx_q | vy_q;
            4'h2: v_wdata = vx_q & vy_q;
            4'h3: v_wdata = vx_q ^ vy_q;
            4'h4: v_wdata = sum9[7:0];
            4'h5: v_wdata = vx_q - vy_q;
            4'h6: v_wdata = {1'b0, vx_q[7:1]};
            4'h7: v_wdata = vy_q - vx_q;
            4'hE: v_wdata = {vx_q[6:0], 1'b0};
            default: begin
              v_we     = 1'b0;
              status_d = ST_UNKNOWN;
            end
          endcase
        end
        4'h9: begin
          if (fn != 4'h0) status_d = ST_UNKNOWN;
          else if (vx_q != vy_q) pc_d = pc_q + 12'd2;
        end
        4'hA: i_d = {4'h0, nnn};
        4'hB: pc_d = nnn + {4'h0, vy_q};
        4'hC: begin
          v_we    = 1'b1;
          v_wdata = rnd_q & kk;
        end
        4'hD: drw_d = 1'b1;
        4'hE: begin
          if (kk == 8'h9E) begin
            if (key_dn) pc_d = pc_q + 12'd2;
          end else if (kk == 8'hA1) begin
            if (!key_dn) pc_d = pc_q + 12'd2;
          end else begin
            status_d = ST_UNKNOWN;
          end
        end
        default: begin
          case (kk)
            8'h07: begin
              v_we    = 1'b1;
              v_wdata = dt_q;
            end
            8'h0A: begin
              if (keys_q == 16'h0000) begin
                pc_d   = pc_q - 12'd2;
                wait_d = 1'b1;
              end else begin
                v_we    = 1'b1;
                v_wdata = {4'h0, kidx};
              end
            end
            8'h15: dt_d = vx_q;
            8'h18: st_d = vx_q;
            8'h1E: i_d = i_q + {8'h00, vx_q};
            8'h29: i_d = 16'(FONT_BASE) + {6'h00, vx_q, 2'b00} + {8'h00, vx_q};
            8'h33, 8'h55, 8'h65: ;
            default: status_d = ST_UNKNOWN;
          endcase
        end
      endcase
    end

    if (cmd_i.flag_wr) begin
      v_we    = 1'b1;
      v_waddr = 4'hF;
      v_wdata = {7'h00, flag};
    end
    if (cmd_i.v_load_wr) begin
      v_we    = 1'b1;
      v_waddr = cnt_q;
      v_wdata = mem_rdata_q;
    end
    if (cmd_i.finish && action_q == ACT_EXEC) begin
      if (dt_q != 8'h00) dt_d = dt_q - 8'd1;
      if (st_q != 8'h00) st_d = st_q - 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= START_PC;
      i_q      <= '0;
      sp_q     <= '0;
      dt_q     <= '0;
      st_q     <= '0;
      cls_q    <= 1'b0;
      drw_q    <= 1'b0;
      wait_q   <= 1'b0;
      status_q <= ST_OK;
      for (int k = 0; k < STACK_DEPTH; k++) stack_q[k] <= '0;
    end else begin
      pc_q     <= pc_d;
      i_q      <= i_d;
      sp_q     <= sp_d;
      dt_q     <= dt_d;
      st_q     <= st_d;
      cls_q    <= cls_d;
      drw_q    <= drw_d;
      wait_q   <= wait_d;
      status_q <= status_d;
      if (stk_we) stack_q[stk_waddr] <= stk_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= '0;
      rd_q <= '0;
    end else begin
      if (cmd_i.op_hi_ld) op_q[15:8] <= mem_rdata_q;
      if (cmd_i.op_lo_ld) op_q[7:0]  <= mem_rdata_q;
      if (cmd_i.rd_ld)    rd_q       <= mem_rdata_q;
    end
    if (cmd_i.vx_ld) vx_q <= v_rdata;
    if (cmd_i.vy_ld) vy_q <= v_rdata;
    if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 4'd1;
    end
  end

  // result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_o.pc            <= pc_q;
      out_o.opcode        <= op_q;
      out_o.read_data     <= rd_q;
      out_o.sound_on      <= st_d != 8'h00;
      out_o.clear_display <= cls_q;
      out_o.draw_request  <= drw_q;
      out_o.waiting_key   <= wait_q;
      out_o.status        <= status_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign stat_o.clr_done = clr_q == MEM_AW'(MEM_BYTES - 1);
  assign stat_o.action   = action_q;
  assign stat_o.op       = op_q;
  assign stat_o.cnt      = cnt_q;
  assign stat_o.out_free = !out_valid_q || out_o.ready;

endmodule
`default_nettype wire

/* hdl/chip8_instruction_core.sv */
`default_nettype none
// CHIP-8 instruction core. After reset the core sweeps all of main memory
// (zero fill plus the hex font at 0x50) and accepts no word until that pass
// ends. Each word then runs on a sequencer around a 4K x 8 memory and a
// 16 x 8 register file, each with one read and one write port: a memory
// write, a memory read, or an execute (fetch of two opcode bytes, two
// register reads, execute, finish), plus a flag write for ALU ops that set
// VF, three digit writes for BCD and x+1 read/write steps for the register
// block store/load. The next word is taken while a finished result still
// waits in the output register. DRW and CLS are reported only, not performed.
module chip8_instruction_core
  import c8core_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  c8core_in_if.sink    in_i,
  c8core_out_if.source out_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  c8core_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  c8core_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire
